/* sv/scct_pkg.sv */
`default_nettype none
package scct_pkg;

  localparam int SLOTS_DEF = 4;

  localparam int KIND_W  = 3;
  localparam int CHAN_W  = 5;
  localparam int LVL_W   = 8;
  localparam int STEP_W  = 7;
  localparam int MASK_W  = 32;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  localparam logic [STEP_W-1:0] STEP_RST  = 7'd5;
  localparam logic [LVL_W-1:0]  LIMIT_RST = 8'sd50;
  localparam logic [LVL_W-1:0]  LVL_MAX   = 8'h7f;
  localparam logic [LVL_W-1:0]  LVL_MIN   = 8'h80;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_ENERGY = 3'd1,
    KIND_NET    = 3'd2,
    KIND_FAIL   = 3'd3,
    KIND_SELECT = 3'd4
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_DERATE_STEP  = 2'd0,
    REG_DERATE_LIMIT = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_APPLY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic walk;
    logic apply;
    logic load_out;
  } ctrl_t;

endpackage
`default_nettype wire

/* sv/scan_channel_candidate_table.sv */
`default_nettype none
// channel  direction  handshake            payload
// in_      slave      in_tvalid/in_tready  tuser kind, tdata channel and level
// out_     master     out_tvalid/out_tready tuser found, tdata choice and mask
// cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a beat is accepted, walked slot by slot through the shared comparator,
// updated in the apply state and then loaded into the output register.
// the result register holds a beat until taken; the block stalls in its finish
// state while the previous result is still waiting. cfg writes are taken in
// any cycle. reset empties all slots and loads the register defaults.
module scan_channel_candidate_table #(
  parameter int SLOTS = scct_pkg::SLOTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [4:0] channel, [12:5] level, [15:13] zero
  input  wire logic [scct_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [2:0] kind
  input  wire logic [scct_pkg::KIND_W-1:0]         in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [4:0] best_channel, [12:5] best_level, [44:13] valid_mask, [47:45] zero
  output logic [scct_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // [0] found
  output logic                                     out_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [scct_pkg::CIDX_W-1:0]         cfg_index,
  input  wire logic [scct_pkg::CDATA_W-1:0]        cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LVL_W = scct_pkg::LVL_W;
  localparam int CHAN_W = scct_pkg::CHAN_W;

  scct_pkg::ctrl_t             ctrl;
  logic [IDX_W-1:0]            idx;
  logic                        in_fire;
  logic                        out_free;

  logic [scct_pkg::STEP_W-1:0] step_r;
  logic signed [LVL_W-1:0]     limit_r;

  logic [scct_pkg::KIND_W-1:0] kind_r;
  logic [CHAN_W-1:0]           chan_r;
  logic signed [LVL_W-1:0]     lvl_in_r;

  logic signed [LVL_W-1:0]     acc_r;
  logic [IDX_W-1:0]            worst_r;
  logic                        hit_r;
  logic [IDX_W-1:0]            hit_idx_r;
  logic signed [LVL_W-1:0]     hit_lvl_r;
  logic                        found_r;
  logic [CHAN_W-1:0]           best_chan_r;
  logic signed [LVL_W-1:0]     best_lvl_r;

  logic                        out_valid_r;
  logic                        out_found_r;
  logic [CHAN_W-1:0]           out_chan_r;
  logic signed [LVL_W-1:0]     out_lvl_r;
  logic [scct_pkg::MASK_W-1:0] out_mask_r;

  logic                        s_valid;
  logic [CHAN_W-1:0]           s_chan;
  logic signed [LVL_W-1:0]     s_lvl;
  logic                        s_match;
  logic                        clr_en;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_idx;
  logic signed [LVL_W-1:0]     wr_lvl;
  logic [scct_pkg::MASK_W-1:0] mask;

  logic signed [LVL_W-1:0]     cmp_a;
  logic                        cmp_lt;
  logic                        cmp_eq;
  logic signed [LVL_W:0]       derated;

  assign in_fire   = in_tvalid & ctrl.in_ready;
  assign in_tready = ctrl.in_ready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  scct_seq #(.SLOTS(SLOTS)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ctrl     (ctrl),
    .idx      (idx)
  );

  scct_table #(.SLOTS(SLOTS)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx),
    .rd_valid (s_valid),
    .rd_chan  (s_chan),
    .rd_lvl   (s_lvl),
    .clr_en   (clr_en),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_chan  (chan_r),
    .wr_lvl   (wr_lvl),
    .mask     (mask)
  );

  // walk compares the slot level, update compares the incoming level
  assign cmp_a = ctrl.apply ? lvl_in_r : s_lvl;

  scct_cmp u_cmp (
    .a      (cmp_a),
    .b      (acc_r),
    .a_lt_b (cmp_lt),
    .a_eq_b (cmp_eq)
  );

  assign s_match = s_valid && (s_chan == chan_r);
  assign derated = {hit_lvl_r[LVL_W-1], hit_lvl_r} + (LVL_W+1)'(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= scct_pkg::STEP_RST;
      limit_r <= scct_pkg::LIMIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == scct_pkg::REG_DERATE_STEP) step_r <= cfg_data[scct_pkg::STEP_W-1:0];
      if (cfg_index == scct_pkg::REG_DERATE_LIMIT) limit_r <= cfg_data[LVL_W-1:0];
    end
  end

  always_comb begin
    clr_en = 1'b0;
    wr_en  = 1'b0;
    wr_idx = worst_r;
    wr_lvl = lvl_in_r;
    if (ctrl.walk) begin
      case (kind_r)
        scct_pkg::KIND_CLEAR: clr_en = 1'b1;
        scct_pkg::KIND_FAIL:  clr_en = s_match;
        default:              clr_en = 1'b0;
      endcase
    end
    if (ctrl.apply) begin
      case (kind_r)
        scct_pkg::KIND_ENERGY: wr_en = cmp_lt;
        scct_pkg::KIND_NET: begin
          wr_en  = hit_r;
          wr_idx = hit_idx_r;
          // saturate against the limit at full width
          wr_lvl = (derated > $signed({limit_r[LVL_W-1], limit_r})) ? limit_r
                                                                     : derated[LVL_W-1:0];
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r      <= in_tuser;
      chan_r      <= in_tdata[CHAN_W-1:0];
      lvl_in_r    <= in_tdata[CHAN_W+LVL_W-1:CHAN_W];
      acc_r       <= (in_tuser == scct_pkg::KIND_ENERGY) ? scct_pkg::LVL_MIN
                                                         : scct_pkg::LVL_MAX;
      worst_r     <= '0;
      hit_r       <= 1'b0;
      hit_idx_r   <= '0;
      hit_lvl_r   <= '0;
      found_r     <= 1'b0;
      best_chan_r <= '0;
      best_lvl_r  <= '0;
    end else if (ctrl.walk) begin
      case (kind_r)
        scct_pkg::KIND_ENERGY: begin
          if (!s_valid) begin
            worst_r <= idx;
            acc_r   <= scct_pkg::LVL_MAX;
          end else if (!cmp_lt) begin
            worst_r <= idx;
            acc_r   <= s_lvl;
          end
        end
        scct_pkg::KIND_NET: begin
          if (!hit_r && s_match) begin
            hit_r     <= 1'b1;
            hit_idx_r <= idx;
            hit_lvl_r <= s_lvl;
          end
        end
        scct_pkg::KIND_SELECT: begin
          if (s_valid && (cmp_lt || cmp_eq)) begin
            found_r     <= 1'b1;
            best_chan_r <= s_chan;
            best_lvl_r  <= s_lvl;
            acc_r       <= s_lvl;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_found_r <= found_r;
      out_chan_r  <= best_chan_r;
      out_lvl_r   <= best_lvl_r;
      out_mask_r  <= mask;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {3'b000, out_mask_r, out_lvl_r, out_chan_r};

endmodule
`default_nettype wire

/* sv/scct_cmp.sv */
`default_nettype none
// shared signed level comparator
module scct_cmp (
  input  wire logic signed [scct_pkg::LVL_W-1:0] a,
  input  wire logic signed [scct_pkg::LVL_W-1:0] b,
  output logic                                   a_lt_b,
  output logic                                   a_eq_b
);

  assign a_lt_b = (a < b);
  assign a_eq_b = (a == b);

endmodule
`default_nettype wire

/* sv/scct_seq.sv */
`default_nettype none
module scct_seq #(
  parameter int SLOTS = scct_pkg::SLOTS_DEF,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              out_free,
  output scct_pkg::ctrl_t        ctrl,
  output logic [IDX_W-1:0]       idx
);

  scct_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              last_slot;

  assign last_slot = (cnt_r == IDX_W'(SLOTS - 1));
  assign idx = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scct_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      scct_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) state_nxt = scct_pkg::ST_WALK;
      end
      scct_pkg::ST_WALK: begin
        if (last_slot) state_nxt = scct_pkg::ST_APPLY;
        else cnt_nxt = cnt_r + 1'b1;
      end
      scct_pkg::ST_APPLY: begin
        state_nxt = scct_pkg::ST_FINISH;
      end
      scct_pkg::ST_FINISH: begin
        if (out_free) state_nxt = scct_pkg::ST_IDLE;
      end
      default: state_nxt = scct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      scct_pkg::ST_IDLE:   ctrl.in_ready = 1'b1;
      scct_pkg::ST_WALK:   ctrl.walk     = 1'b1;
      scct_pkg::ST_APPLY:  ctrl.apply    = 1'b1;
      scct_pkg::ST_FINISH: ctrl.load_out = out_free;
      default:             ctrl = '0;
    endcase
  end

endmodule
`default_nettype wire

/* sv/scct_table.sv */
`default_nettype none
module scct_table #(
  parameter int SLOTS = scct_pkg::SLOTS_DEF,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [IDX_W-1:0]                     rd_idx,
  output logic                                      rd_valid,
  output logic [scct_pkg::CHAN_W-1:0]               rd_chan,
  output logic signed [scct_pkg::LVL_W-1:0]         rd_lvl,
  input  wire logic                                 clr_en,
  input  wire logic                                 wr_en,
  input  wire logic [IDX_W-1:0]                     wr_idx,
  input  wire logic [scct_pkg::CHAN_W-1:0]          wr_chan,
  input  wire logic signed [scct_pkg::LVL_W-1:0]    wr_lvl,
  output logic [scct_pkg::MASK_W-1:0]               mask
);

  logic [SLOTS-1:0]                       valid_r;
  logic [scct_pkg::CHAN_W-1:0]            chan_r [SLOTS];
  logic signed [scct_pkg::LVL_W-1:0]      lvl_r  [SLOTS];

  assign rd_valid = valid_r[rd_idx];
  assign rd_chan  = chan_r[rd_idx];
  assign rd_lvl   = lvl_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (clr_en) valid_r[rd_idx] <= 1'b0;
      if (wr_en)  valid_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      chan_r[wr_idx] <= wr_chan;
      lvl_r[wr_idx]  <= wr_lvl;
    end
  end

  // one-hot per valid slot, or-ed together
  always_comb begin
    mask = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (valid_r[i]) mask = mask | (scct_pkg::MASK_W'(1) << chan_r[i]);
    end
  end

endmodule
`default_nettype wire
